// ----- src/assert_macros.svh -----
// assertion macros shared by the receiver modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on the module clock, off while in reset
`define SFR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition that must never hold
`define SFR_NEVER(lbl, cond, msg) \
    `SFR_ASSERT(lbl, !(cond), msg)

`endif

// ----- src/sfr_crc8_pkg.sv -----
// shared constants and types of the serial frame receiver
package sfr_crc8_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int BYTE_W      = 8;
    localparam int IDX_W       = $clog2(MAX_PAYLOAD);
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int MEM_AW      = IDX_W + 1;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLYNOMIAL = 2'd1;

    localparam logic [CNT_W-1:0]  LEN_RESET  = 7'd1;
    localparam logic [BYTE_W-1:0] POLY_RESET = 8'h8C;

    localparam logic [BYTE_W-1:0] SYNC_BYTE   = 8'h06;
    localparam logic [BYTE_W-1:0] SECOND_BYTE = 8'h85;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_SECOND = 2'd1,
        PH_LENGTH = 2'd2,
        PH_DATA   = 2'd3
    } t_phase;

    // one verified frame waiting to be sent out
    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] count;
    } t_cmd;

    // back end tells the front end a bank has been read out
    typedef struct packed {
        logic valid;
        logic bank;
    } t_drain_done;

endpackage

// ----- src/serial_frame_receiver_crc8_unit.sv -----
// Serial frame receiver with reflected crc-8 check, top level.
// Input: one rx byte per cycle; data-phase bytes stall on a draining bank or a full queue.
// Output: after the checksum transfer, bytes go through the command queue, the store read
// and the output register, with a single read in flight on the payload store port.
// Reset: synchronous active low; payload_length 1, crc_polynomial 0x8C, no clearing pass.
// Two store banks let the next frame fill while the previous burst is sent.
module serial_frame_receiver_crc8_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_rx_valid,
    output logic                                o_rx_stall,
    input  logic [sfr_crc8_pkg::BYTE_W-1:0]     i_rx_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [sfr_crc8_pkg::BYTE_W-1:0]     o_payload_byte,
    output logic [sfr_crc8_pkg::IDX_W-1:0]      o_byte_index,
    output logic                                o_last_byte,
    input  logic                                i_cfg_we,
    input  logic [sfr_crc8_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sfr_crc8_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sfr_crc8_pkg::*;

    logic              wr_en;
    logic [MEM_AW-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              push;
    t_cmd              cmd;
    logic              q_full;
    logic              q_empty;
    t_cmd              q_head;
    logic              pop;
    t_drain_done       done;

    sfr_crc8_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_stall (o_rx_stall),
        .i_rx_byte  (i_rx_byte),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_push     (push),
        .o_cmd      (cmd),
        .i_q_full   (q_full),
        .i_done     (done)
    );

    sfr_crc8_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_head  (q_head)
    );

    sfr_crc8_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr_en        (wr_en),
        .i_wr_addr      (wr_addr),
        .i_wr_data      (wr_data),
        .i_q_empty      (q_empty),
        .i_q_head       (q_head),
        .o_pop          (pop),
        .o_done         (done),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_payload_byte (o_payload_byte),
        .o_byte_index   (o_byte_index),
        .o_last_byte    (o_last_byte)
    );

endmodule

// ----- src/sfr_crc8_front.sv -----
// frame parser: sync hunt, length check, payload store writes and crc check
`include "assert_macros.svh"

module sfr_crc8_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_rx_valid,
    output logic                                   o_rx_stall,
    input  logic [sfr_crc8_pkg::BYTE_W-1:0]        i_rx_byte,
    input  logic                                   i_cfg_we,
    input  logic [sfr_crc8_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sfr_crc8_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                   o_wr_en,
    output logic [sfr_crc8_pkg::MEM_AW-1:0]        o_wr_addr,
    output logic [sfr_crc8_pkg::BYTE_W-1:0]        o_wr_data,
    output logic                                   o_push,
    output sfr_crc8_pkg::t_cmd                     o_cmd,
    input  logic                                   i_q_full,
    input  sfr_crc8_pkg::t_drain_done              i_done
);
    import sfr_crc8_pkg::*;

    t_phase              r_phase, n_phase;
    logic [CNT_W-1:0]    r_count;
    logic [BYTE_W-1:0]   r_crc;
    logic                r_bank;
    logic [1:0]          r_bank_busy;
    logic [CNT_W-1:0]    r_len;
    logic [BYTE_W-1:0]   r_poly;

    logic                take;
    logic                store_ok;
    logic                len_ok;
    logic                crc_match;
    logic [BYTE_W-1:0]   crc_next;

    // lsb-first reflected crc over one byte
    function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data,
                                                    input logic [BYTE_W-1:0] poly);
        logic [BYTE_W-1:0] c;
        logic [BYTE_W-1:0] d;
        logic              fb;
        c = crc;
        d = data;
        for (int i = 0; i < BYTE_W; i++) begin
            fb = c[0] ^ d[0];
            c  = c >> 1;
            if (fb) begin
                c = c ^ poly;
            end
            d = d >> 1;
        end
        return c;
    endfunction

    // bytes of the data phase wait while the current bank is still being sent out or the command queue is full
    assign o_rx_stall = (r_phase == PH_DATA) && (r_bank_busy[r_bank] || i_q_full);
    assign take       = i_rx_valid && !o_rx_stall;

    assign store_ok  = (r_count < r_len) && (r_count < CNT_W'(MAX_PAYLOAD));
    assign len_ok    = (i_rx_byte == BYTE_W'(r_len)) && (r_len != '0)
                       && (r_len <= CNT_W'(MAX_PAYLOAD));
    assign crc_match = (i_rx_byte == r_crc);
    assign crc_next  = crc8_byte(r_crc, i_rx_byte, r_poly);

    always_comb begin
        n_phase = r_phase;
        if (take) begin
            unique case (r_phase)
                PH_HUNT:   n_phase = (i_rx_byte == SYNC_BYTE) ? PH_SECOND : PH_HUNT;
                PH_SECOND: n_phase = (i_rx_byte == SECOND_BYTE) ? PH_LENGTH : PH_HUNT;
                PH_LENGTH: n_phase = len_ok ? PH_DATA : PH_HUNT;
                PH_DATA:   n_phase = store_ok ? PH_DATA : PH_HUNT;
                default:   n_phase = PH_HUNT;
            endcase
        end
    end

    always_comb begin
        o_wr_en     = take && (r_phase == PH_DATA) && store_ok;
        o_wr_addr   = {r_bank, r_count[IDX_W-1:0]};
        o_wr_data   = i_rx_byte;
        // an empty burst sends nothing
        o_push      = take && (r_phase == PH_DATA) && !store_ok && crc_match
                      && (r_count != '0);
        o_cmd.bank  = r_bank;
        o_cmd.count = r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_count     <= '0;
            r_crc       <= '0;
            r_bank      <= 1'b0;
            r_bank_busy <= '0;
            r_len       <= LEN_RESET;
            r_poly      <= POLY_RESET;
        end else begin
            r_phase <= n_phase;
            if (take && (r_phase == PH_LENGTH)) begin
                r_count <= '0;
                r_crc   <= '0;
            end else if (o_wr_en) begin
                r_count <= r_count + CNT_W'(1);
                r_crc   <= crc_next;
            end else if (take && (r_phase == PH_DATA)) begin
                r_count <= '0;
                r_crc   <= '0;
            end
            if (o_push) begin
                r_bank <= ~r_bank;
            end
            for (int b = 0; b < 2; b++) begin
                if (o_push && (r_bank == 1'(b))) begin
                    r_bank_busy[b] <= 1'b1;
                end else if (i_done.valid && (i_done.bank == 1'(b))) begin
                    r_bank_busy[b] <= 1'b0;
                end
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PAYLOAD_LENGTH: r_len  <= i_cfg_data[CNT_W-1:0];
                    CFG_CRC_POLYNOMIAL: r_poly <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    `SFR_NEVER(a_wr_busy_bank, o_wr_en && r_bank_busy[r_bank], "payload written into a bank still draining")
    `SFR_NEVER(a_push_full, o_push && i_q_full, "frame command pushed into a full queue")

endmodule

// ----- src/sfr_crc8_cmdq.sv -----
// two-entry queue of verified frame commands between parser and sender
module sfr_crc8_cmdq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sfr_crc8_pkg::t_cmd  i_cmd,
    input  logic                i_pop,
    output logic                o_empty,
    output logic                o_full,
    output sfr_crc8_pkg::t_cmd  o_head
);
    import sfr_crc8_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;

    logic       do_push;
    logic       do_pop;

    assign o_empty = (r_fill == 2'd0);
    assign o_full  = (r_fill == 2'd2);
    assign o_head  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

endmodule

// ----- src/sfr_crc8_back.sv -----
// payload store and burst sender with registered output
`include "assert_macros.svh"

module sfr_crc8_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr_en,
    input  logic [sfr_crc8_pkg::MEM_AW-1:0]   i_wr_addr,
    input  logic [sfr_crc8_pkg::BYTE_W-1:0]   i_wr_data,
    input  logic                              i_q_empty,
    input  sfr_crc8_pkg::t_cmd                i_q_head,
    output logic                              o_pop,
    output sfr_crc8_pkg::t_drain_done         o_done,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [sfr_crc8_pkg::BYTE_W-1:0]   o_payload_byte,
    output logic [sfr_crc8_pkg::IDX_W-1:0]    o_byte_index,
    output logic                              o_last_byte
);
    import sfr_crc8_pkg::*;

    logic [BYTE_W-1:0] r_mem [2*MAX_PAYLOAD];

    logic              r_active;
    logic              r_bank;
    logic [CNT_W-1:0]  r_cnt;
    logic [IDX_W-1:0]  r_idx;

    logic              r_rd_pend;
    logic [BYTE_W-1:0] r_rd_data;
    logic [IDX_W-1:0]  r_rd_idx;
    logic              r_rd_last;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic [IDX_W-1:0]  r_out_idx;
    logic              r_out_last;

    logic              take_out;
    logic              issue;
    logic              is_last;

    assign take_out = r_out_valid && !i_out_stall;
    // one read in flight; it lands in an output register that is sure to be free
    assign issue    = r_active && !r_rd_pend && (!r_out_valid || take_out);
    assign is_last  = ((CNT_W'(r_idx) + CNT_W'(1)) == r_cnt);
    assign o_pop    = !r_active && !i_q_empty;

    assign o_done.valid = issue && is_last;
    assign o_done.bank  = r_bank;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (issue) begin
            r_rd_data <= r_mem[{r_bank, r_idx}];
            r_rd_idx  <= r_idx;
            r_rd_last <= is_last;
        end
        if (r_rd_pend) begin
            r_out_byte <= r_rd_data;
            r_out_idx  <= r_rd_idx;
            r_out_last <= r_rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_bank      <= 1'b0;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_active <= 1'b1;
                r_bank   <= i_q_head.bank;
                r_cnt    <= i_q_head.count;
                r_idx    <= '0;
            end else if (issue) begin
                r_idx <= r_idx + IDX_W'(1);
                if (is_last) begin
                    r_active <= 1'b0;
                end
            end
            r_rd_pend <= issue;
            if (r_rd_pend) begin
                r_out_valid <= 1'b1;
            end else if (take_out) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_payload_byte = r_out_byte;
    assign o_byte_index   = r_out_idx;
    assign o_last_byte    = r_out_last;

    `SFR_NEVER(a_pend_on_full, r_rd_pend && r_out_valid, "read data arrived while output register held a byte")
    `SFR_ASSERT(a_last_ends, (issue && is_last) |=> !r_active, "sender still active after last read")

endmodule

// ----- sim/testbench.sv -----
// self-checking testbench for the serial frame receiver with crc-8 check
`timescale 1ns / 1ps

module testbench;
    import sfr_crc8_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 20;
    localparam int END_TAIL       = 2 * MAX_PAYLOAD + 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_BYTES    = 68;
    localparam int NUM_SETTINGS   = 6;
    localparam int MAX_REPORTS    = 50;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_3 = 2'd3;

    typedef enum logic [1:0] {
        ROW_RX  = 2'd0,
        ROW_CRC = 2'd1,
        ROW_CFG = 2'd2
    } t_row_kind;

    // ROW_CRC sends the running checksum xor data
    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [BYTE_W-1:0]     data;
        logic                  typed;
        logic [BYTE_W-1:0]     t_byte;
        logic [IDX_W-1:0]      t_idx;
        logic                  t_last;
    } t_row;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  idx;
        logic              last;
    } t_beat;

    localparam int NUM_ROWS = 33;
    localparam t_row DIRECTED [NUM_ROWS] = '{
        // reset settings: one zero byte, checksum zero
        '{kind: ROW_RX,  data: 8'h06, default: 0},
        '{kind: ROW_RX,  data: 8'h85, default: 0},
        '{kind: ROW_RX,  data: 8'h01, default: 0},
        '{kind: ROW_RX,  data: 8'h00, default: 0},
        '{kind: ROW_CRC, data: 8'h00, typed: 1'b1, t_byte: 8'h00, t_idx: 6'd0,
          t_last: 1'b1, default: 0},
        // a sync byte in second position is not taken as a new sync
        '{kind: ROW_RX,  data: 8'h06, default: 0},
        '{kind: ROW_RX,  data: 8'h06, default: 0},
        '{kind: ROW_RX,  data: 8'h85, default: 0},
        '{kind: ROW_RX,  data: 8'h01, default: 0},
        // bad checksum, frame dropped
        '{kind: ROW_RX,  data: 8'h06, default: 0},
        '{kind: ROW_RX,  data: 8'h85, default: 0},
        '{kind: ROW_RX,  data: 8'h01, default: 0},
        '{kind: ROW_RX,  data: 8'h5A, default: 0},
        '{kind: ROW_CRC, data: 8'h01, default: 0},
        '{kind: ROW_CFG, idx: CFG_UNUSED_2, data: 8'h00, default: 0},
        '{kind: ROW_CFG, idx: CFG_UNUSED_3, data: 8'hFF, default: 0},
        // zero length never opens a frame
        '{kind: ROW_CFG, idx: CFG_PAYLOAD_LENGTH, data: 8'h00, default: 0},
        '{kind: ROW_RX,  data: 8'h06, default: 0},
        '{kind: ROW_RX,  data: 8'h85, default: 0},
        '{kind: ROW_RX,  data: 8'h00, default: 0},
        // 0xc1 masks to 65, above the store size
        '{kind: ROW_CFG, idx: CFG_PAYLOAD_LENGTH, data: 8'hC1, default: 0},
        '{kind: ROW_RX,  data: 8'h06, default: 0},
        '{kind: ROW_RX,  data: 8'h85, default: 0},
        '{kind: ROW_RX,  data: 8'h41, default: 0},
        // length drops under the stored count mid-frame
        '{kind: ROW_CFG, idx: CFG_CRC_POLYNOMIAL, data: 8'hFF, default: 0},
        '{kind: ROW_CFG, idx: CFG_PAYLOAD_LENGTH, data: 8'h03, default: 0},
        '{kind: ROW_RX,  data: 8'h06, default: 0},
        '{kind: ROW_RX,  data: 8'h85, default: 0},
        '{kind: ROW_RX,  data: 8'h03, default: 0},
        '{kind: ROW_RX,  data: 8'h80, default: 0},
        '{kind: ROW_RX,  data: 8'h01, default: 0},
        '{kind: ROW_CFG, idx: CFG_PAYLOAD_LENGTH, data: 8'h01, default: 0},
        '{kind: ROW_CRC, data: 8'h00, default: 0}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_rx_valid;
    logic                  o_rx_stall;
    logic [BYTE_W-1:0]     i_rx_byte;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [BYTE_W-1:0]     o_payload_byte;
    logic [IDX_W-1:0]      o_byte_index;
    logic                  o_last_byte;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // deframer state and register copies
    t_phase            fr_phase;
    logic [CNT_W-1:0]  fr_count;
    logic [BYTE_W-1:0] fr_crc;
    logic [BYTE_W-1:0] fr_store [MAX_PAYLOAD];
    logic [CNT_W-1:0]  cfg_len;
    logic [BYTE_W-1:0] cfg_poly;

    t_beat pending_beats [$];

    int errors;
    int rx_count;
    int dir_rx_count;
    int out_count;
    int cfg_count;
    int idle_cycles;
    int stall_left;
    int quiet_left;

    serial_frame_receiver_crc8_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_valid     (i_rx_valid),
        .o_rx_stall     (o_rx_stall),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_payload_byte (o_payload_byte),
        .o_byte_index   (o_byte_index),
        .o_last_byte    (o_last_byte),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    // reflected crc-8, lsb first
    function automatic logic [BYTE_W-1:0] crc8_next(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b,
                                                    input logic [BYTE_W-1:0] poly);
        logic fb;
        for (int i = 0; i < BYTE_W; i++) begin
            fb  = crc[0] ^ b[0];
            crc = crc >> 1;
            if (fb)
                crc = crc ^ poly;
            b = b >> 1;
        end
        return crc;
    endfunction

    // advance the deframer by one rx byte, queue the burst on a checksum match when emit is set
    task automatic deframe_byte(input logic [BYTE_W-1:0] b, input bit emit);
        t_beat beat;
        case (fr_phase)
            PH_HUNT: begin
                if (b == SYNC_BYTE)
                    fr_phase = PH_SECOND;
            end
            PH_SECOND: begin
                fr_phase = (b == SECOND_BYTE) ? PH_LENGTH : PH_HUNT;
            end
            PH_LENGTH: begin
                if (b == {1'b0, cfg_len} && cfg_len != 0 && cfg_len <= MAX_PAYLOAD) begin
                    fr_phase = PH_DATA;
                    fr_count = '0;
                    fr_crc   = '0;
                end else begin
                    fr_phase = PH_HUNT;
                end
            end
            default: begin
                if (fr_count < cfg_len && fr_count < MAX_PAYLOAD) begin
                    fr_store[fr_count[IDX_W-1:0]] = b;
                    fr_crc                        = crc8_next(fr_crc, b, cfg_poly);
                    fr_count                      = fr_count + 1'b1;
                end else begin
                    if (b == fr_crc && emit) begin
                        for (int k = 0; k < fr_count; k++) begin
                            beat.data = fr_store[k];
                            beat.idx  = IDX_W'(k);
                            beat.last = (k + 1 == fr_count);
                            pending_beats.push_back(beat);
                        end
                    end
                    fr_phase = PH_HUNT;
                    fr_count = '0;
                    fr_crc   = '0;
                end
            end
        endcase
    endtask

    function automatic int rx_gap(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // entered and left right after a rising edge; valid stays high on return
    task automatic send_rx(input logic [BYTE_W-1:0] b, input bit emit, input int gap);
        if (gap > 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_rx_stall);
        rx_count++;
        deframe_byte(b, emit);
    endtask

    // only with nothing in flight
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_rx_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_count++;
        if (idx == CFG_PAYLOAD_LENGTH)
            cfg_len = data[CNT_W-1:0];
        else if (idx == CFG_CRC_POLYNOMIAL)
            cfg_poly = data;
    endtask

    task automatic send_frame();
        int r;
        int n;
        bit burst;
        logic [BYTE_W-1:0] b;
        burst = ($urandom_range(0, 3) == 0);
        r     = $urandom_range(0, 99);
        if (r < 75) begin
            send_rx(SYNC_BYTE, 1'b1, rx_gap(burst));
            send_rx(SECOND_BYTE, 1'b1, rx_gap(burst));
            send_rx({1'b0, cfg_len}, 1'b1, rx_gap(burst));
            for (int k = 0; k < cfg_len; k++)
                send_rx(BYTE_W'($urandom_range(0, 255)), 1'b1, rx_gap(burst));
            b = fr_crc;
            if (r >= 60)
                b = b ^ BYTE_W'($urandom_range(1, 255));
            send_rx(b, 1'b1, rx_gap(burst));
        end else if (r < 83) begin
            send_rx(SYNC_BYTE, 1'b1, rx_gap(burst));
            b = BYTE_W'($urandom_range(0, 255));
            if (b == SECOND_BYTE)
                b = ~b;
            send_rx(b, 1'b1, rx_gap(burst));
        end else if (r < 90) begin
            send_rx(SYNC_BYTE, 1'b1, rx_gap(burst));
            send_rx(SECOND_BYTE, 1'b1, rx_gap(burst));
            b = BYTE_W'($urandom_range(0, 255));
            if (b == {1'b0, cfg_len})
                b = b ^ 8'h80;
            send_rx(b, 1'b1, rx_gap(burst));
        end else begin
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++) begin
                b = ($urandom_range(0, 3) == 0) ? SYNC_BYTE : BYTE_W'($urandom_range(0, 255));
                send_rx(b, 1'b1, rx_gap(burst));
            end
        end
    endtask

    task automatic report_field(input string fname, input logic [BYTE_W-1:0] want,
                                input logic [BYTE_W-1:0] got);
        if (errors < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
        errors++;
    endtask

    // output side: random stall and compare against the oldest expected beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            out_count++;
            if (pending_beats.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: unexpected payload transfer, expected none, got %0h idx %0d last %0d",
                             $time, o_payload_byte, o_byte_index, o_last_byte);
                errors++;
            end else begin
                if (o_payload_byte !== pending_beats[0].data)
                    report_field("payload_byte", pending_beats[0].data, o_payload_byte);
                if (o_byte_index !== pending_beats[0].idx)
                    report_field("byte_index", BYTE_W'(pending_beats[0].idx),
                                 BYTE_W'(o_byte_index));
                if (o_last_byte !== pending_beats[0].last)
                    report_field("last_byte", BYTE_W'(pending_beats[0].last),
                                 BYTE_W'(o_last_byte));
                void'(pending_beats.pop_front());
            end
        end
        if (quiet_left > 0) begin
            quiet_left--;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5: begin
                    stall_left = $urandom_range(0, 2);
                    i_out_stall <= 1'b1;
                end
                6: begin
                    stall_left = $urandom_range(10, 40);
                    i_out_stall <= 1'b1;
                end
                7: begin
                    quiet_left = $urandom_range(20, 80);
                    i_out_stall <= 1'b0;
                end
                default: i_out_stall <= 1'b0;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((i_rx_valid && !o_rx_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d beats still expected",
                     $time, idle_cycles, pending_beats.size());
            $display("serial_frame_receiver_crc8_unit verification failed");
            $finish;
        end
    end

    initial begin
        t_row              row;
        logic [CNT_W-1:0]  set_len  [NUM_SETTINGS];
        logic [BYTE_W-1:0] set_poly [NUM_SETTINGS];
        int                phase_start;

        errors      = 0;
        rx_count    = 0;
        out_count   = 0;
        cfg_count   = 0;
        idle_cycles = 0;
        stall_left  = 0;
        quiet_left  = 0;
        fr_phase    = PH_HUNT;
        fr_count    = '0;
        fr_crc      = '0;
        cfg_len     = LEN_RESET;
        cfg_poly    = POLY_RESET;

        i_rst_n     <= 1'b0;
        i_rx_valid  <= 1'b0;
        i_rx_byte   <= '0;
        i_out_stall <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_PAYLOAD_LENGTH;
        i_cfg_data  <= '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NUM_ROWS; r++) begin
            row = DIRECTED[r];
            case (row.kind)
                ROW_CFG: write_reg(row.idx, row.data);
                ROW_RX:  send_rx(row.data, 1'b1, rx_gap(1'b0));
                default: begin
                    send_rx(fr_crc ^ row.data, !row.typed, rx_gap(1'b0));
                    if (row.typed)
                        pending_beats.push_back('{data: row.t_byte, idx: row.t_idx,
                                                  last: row.t_last});
                end
            endcase
        end
        dir_rx_count = rx_count;

        // full store once, then short frames under several polynomials
        set_len[0]  = CNT_W'(MAX_PAYLOAD);
        set_poly[0] = BYTE_W'($urandom_range(0, 255));
        set_len[1]  = 7'd1;
        set_poly[1] = 8'h00;
        set_len[2]  = CNT_W'($urandom_range(2, 8));
        set_poly[2] = 8'hFF;
        for (int p = 3; p < NUM_SETTINGS; p++) begin
            set_len[p]  = CNT_W'($urandom_range(1, 12));
            set_poly[p] = BYTE_W'($urandom_range(0, 255));
        end

        for (int p = 0; p < NUM_SETTINGS; p++) begin
            write_reg(CFG_CRC_POLYNOMIAL, set_poly[p]);
            // bit 7 of the length write is unused
            write_reg(CFG_PAYLOAD_LENGTH, {1'($urandom_range(0, 1)), set_len[p]});
            phase_start = rx_count;
            while (rx_count - phase_start < PHASE_BYTES)
                send_frame();
        end
        i_rx_valid <= 1'b0;

        while (pending_beats.size() != 0)
            @(posedge i_clk);
        repeat (END_TAIL) @(posedge i_clk);

        $display("covered %0d rx transfers (%0d directed) and %0d register writes,",
                 rx_count, dir_rx_count, cfg_count);
        $display("%0d payload transfers checked over %0d register settings, %0d errors",
                 out_count, NUM_SETTINGS, errors);
        if (errors == 0)
            $display("serial_frame_receiver_crc8_unit verification clean");
        else
            $display("serial_frame_receiver_crc8_unit verification failed");
        $finish;
    end

endmodule
